### sv/lkfc_pkg.sv
// Shared types and constants for the keyed frame cache directory.
package lkfc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int SLOT_W      = 4;
  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0] MAX_FRAMES_RST = CFG_W'(16);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_UPDATE,
    ST_UPD_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic step;
    logic upd;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic need_upd;
  } sts_t;

  typedef struct packed {
    logic [KEY_W-1:0]  evicted_key;
    logic              evicted;
    logic              inserted;
    logic [SLOT_W-1:0] slot;
    logic              hit;
  } res_t;

endpackage

### sv/lkfc_ctrl.sv
// Frame cache sequencer: scan, decision, rank update if needed, result hand-off.
module lkfc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_op,
  input  logic           out_free,
  input  lkfc_pkg::sts_t sts,
  output logic           in_ready,
  output lkfc_pkg::cmd_t cmd
);

  lkfc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lkfc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_op == lkfc_pkg::OP_CLEAR) ? lkfc_pkg::ST_DONE : lkfc_pkg::ST_SCAN;
        end
      end
      lkfc_pkg::ST_SCAN: begin
        if (sts.last) state_next = lkfc_pkg::ST_SCAN_END;
      end
      lkfc_pkg::ST_SCAN_END: state_next = lkfc_pkg::ST_DECIDE;
      lkfc_pkg::ST_DECIDE: begin
        state_next = sts.need_upd ? lkfc_pkg::ST_UPDATE : lkfc_pkg::ST_DONE;
      end
      lkfc_pkg::ST_UPDATE: begin
        if (sts.last) state_next = lkfc_pkg::ST_UPD_END;
      end
      lkfc_pkg::ST_UPD_END: state_next = lkfc_pkg::ST_DONE;
      lkfc_pkg::ST_DONE: begin
        if (out_free) state_next = lkfc_pkg::ST_IDLE;
      end
      default: state_next = lkfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      lkfc_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && (in_op == lkfc_pkg::OP_LOOKUP);
        cmd.clear = in_valid && (in_op == lkfc_pkg::OP_CLEAR);
      end
      lkfc_pkg::ST_SCAN: cmd.step = 1'b1;
      lkfc_pkg::ST_DECIDE: cmd.decide = 1'b1;
      lkfc_pkg::ST_UPDATE: begin
        cmd.step = 1'b1;
        cmd.upd  = 1'b1;
      end
      lkfc_pkg::ST_DONE: cmd.emit = out_free;
      default: ;
    endcase
  end

endmodule

### sv/lkfc_dp.sv
// Datapath: key/rank memory, valid bits, scan trackers, decision and result registers.
module lkfc_dp #(
  parameter int ENTRIES = lkfc_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lkfc_pkg::cmd_t             cmd,
  input  logic [lkfc_pkg::KEY_W-1:0] in_key,
  input  logic                       in_fill,
  input  logic                       cfg_we,
  input  logic [lkfc_pkg::CFG_W-1:0] cfg_data,
  output lkfc_pkg::sts_t             sts,
  output lkfc_pkg::res_t             res
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = IDX_W;
  localparam int MEM_W  = lkfc_pkg::KEY_W + RANK_W;
  localparam int UW     = $clog2(ENTRIES + 1);
  localparam int CW     = (UW > lkfc_pkg::CFG_W) ? UW : lkfc_pkg::CFG_W;

  logic [MEM_W-1:0] mem [ENTRIES];

  logic [ENTRIES-1:0]          valid;
  logic [UW-1:0]               used;
  logic [lkfc_pkg::CFG_W-1:0]  max_frames;
  logic [IDX_W-1:0]            cnt;
  logic                        rd_vld, rd_upd;
  logic [IDX_W-1:0]            rd_idx;
  logic [MEM_W-1:0]            rd_data;
  logic [lkfc_pkg::KEY_W-1:0]  key_q;
  logic                        fill_q;

  logic                        f_vld, o_vld, e_vld;
  logic [IDX_W-1:0]            f_idx, o_idx, e_idx;
  logic [RANK_W-1:0]           f_rank, o_rank;
  logic [lkfc_pkg::KEY_W-1:0]  o_key;

  logic [IDX_W-1:0]            tgt;
  logic [RANK_W-1:0]           thr;
  logic                        inc_all;

  logic [lkfc_pkg::KEY_W-1:0]  rd_key;
  logic [RANK_W-1:0]           rd_rank;
  logic                        rd_v, ev_scan, wr_en;
  logic [MEM_W-1:0]            wr_data;
  logic [CW-1:0]               mf_ext, lim;
  logic                        lim_hit, do_evict;
  lkfc_pkg::res_t              res_next;

  assign rd_key  = rd_data[MEM_W-1:RANK_W];
  assign rd_rank = rd_data[RANK_W-1:0];
  assign rd_v    = valid[rd_idx];
  assign ev_scan = rd_vld && !rd_upd;

  assign mf_ext  = CW'(max_frames);
  assign lim     = (mf_ext == '0) ? CW'(1) : ((mf_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : mf_ext);
  assign lim_hit = CW'(used) >= lim;
  assign do_evict = lim_hit && o_vld;

  assign sts.last     = (cnt == IDX_W'(ENTRIES - 1));
  assign sts.need_upd = f_vld || fill_q;

  assign wr_en = rd_vld && rd_upd &&
                 ((rd_idx == tgt) || (rd_v && (inc_all || (rd_rank < thr))));
  assign wr_data = (rd_idx == tgt) ? {key_q, RANK_W'(0)}
                                   : {rd_key, RANK_W'(rd_rank + 1'b1)};

  always_comb begin
    res_next = '0;
    if (f_vld) begin
      res_next.hit  = 1'b1;
      res_next.slot = lkfc_pkg::SLOT_W'(f_idx);
    end else if (fill_q) begin
      res_next.inserted = 1'b1;
      if (do_evict) begin
        res_next.slot        = lkfc_pkg::SLOT_W'(o_idx);
        res_next.evicted     = 1'b1;
        res_next.evicted_key = o_key;
      end else begin
        res_next.slot = lkfc_pkg::SLOT_W'(e_idx);
      end
    end
  end

  // key/rank store, one read and one write a cycle
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_data <= mem[cnt];
      rd_idx  <= cnt;
    end
    if (wr_en) mem[rd_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      used       <= '0;
      max_frames <= lkfc_pkg::MAX_FRAMES_RST;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      rd_upd     <= 1'b0;
      f_vld      <= 1'b0;
      o_vld      <= 1'b0;
      e_vld      <= 1'b0;
    end else begin
      if (cfg_we) max_frames <= cfg_data;
      rd_vld <= cmd.step;
      rd_upd <= cmd.upd;
      if (cmd.load || cmd.decide) begin
        cnt <= '0;
      end else if (cmd.step) begin
        cnt <= sts.last ? '0 : IDX_W'(cnt + 1'b1);
      end
      if (cmd.load) begin
        f_vld <= 1'b0;
        o_vld <= 1'b0;
        e_vld <= 1'b0;
      end else if (ev_scan) begin
        if (rd_v && (rd_key == key_q) && !f_vld) f_vld <= 1'b1;
        if (rd_v) o_vld <= 1'b1;
        if (!rd_v) e_vld <= 1'b1;
      end
      if (cmd.clear) begin
        valid <= '0;
        used  <= '0;
      end else if (cmd.decide && !f_vld && fill_q && !do_evict) begin
        valid[e_idx] <= 1'b1;
        used         <= UW'(used + 1'b1);
      end
    end
  end

  // scan trackers and decision registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= in_key;
      fill_q <= in_fill;
    end
    if (ev_scan) begin
      if (rd_v && (rd_key == key_q) && !f_vld) begin
        f_idx  <= rd_idx;
        f_rank <= rd_rank;
      end
      if (rd_v && (!o_vld || (rd_rank > o_rank))) begin
        o_idx  <= rd_idx;
        o_rank <= rd_rank;
        o_key  <= rd_key;
      end
      if (!rd_v && !e_vld) e_idx <= rd_idx;
    end
    if (cmd.clear) begin
      res <= '0;
    end else if (cmd.decide) begin
      res <= res_next;
      if (f_vld) begin
        tgt     <= f_idx;
        thr     <= f_rank;
        inc_all <= 1'b0;
      end else if (fill_q) begin
        if (do_evict) begin
          tgt     <= o_idx;
          thr     <= o_rank;
          inc_all <= 1'b0;
        end else begin
          tgt     <= e_idx;
          inc_all <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(ENTRIES))
    else $error("used count above entry count");

  a_used_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(used))
    else $error("used count disagrees with valid bits");

  a_fill_inserts: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && !f_vld && fill_q) |=> res.inserted)
    else $error("fill on miss did not insert");

  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(cmd.step && cmd.upd))
    else $error("store written outside update pass");
`endif

endmodule

### sv/lru_keyed_frame_cache.sv
// Top level of the LRU keyed frame cache directory.
// Input beats on s_axis: tuser[0] is the operation (0 lookup/fill, 1 clear),
// tdata carries the frame key and the fill flag. One result beat on m_axis
// per input beat, in order. max_frames is written on the cfg channel, which
// is always ready; write it only while the block is idle.
// A lookup scans all ENTRIES slots of the key/rank store, one a cycle; on a
// hit or a fill a second pass then rewrites ranks (and the key on insert).
// One item is in work at a time; the single store port serves both passes.
// The next beat is taken as soon as the result sits in the output register;
// if the receiver stalls, the following result waits in the sequencer and
// s_axis_tready stays low until the output register drains.
// Reset empties the directory and sets max_frames to 16; no clearing pass.
module lru_keyed_frame_cache #(
  parameter int ENTRIES = lkfc_pkg::ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lkfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // frame_key[31:0], fill_ok[32], zero
  input  logic [0:0]                       s_axis_tuser,  // operation[0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lkfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // hit[0], slot[4:1], inserted[5],
                                                          // evicted[6], evicted_key[38:7], zero
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lkfc_pkg::CFG_W-1:0]       cfg_data
);

  lkfc_pkg::cmd_t cmd;
  lkfc_pkg::sts_t sts;
  lkfc_pkg::res_t res;
  logic           out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  lkfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser[0]),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  lkfc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_key   (s_axis_tdata[lkfc_pkg::KEY_W-1:0]),
    .in_fill  (s_axis_tdata[lkfc_pkg::KEY_W]),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .sts      (sts),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) m_axis_tdata <= lkfc_pkg::OUT_TDATA_W'(res);
  end

endmodule
